// File: src/potl_pkg.sv
// Shared types and constants for the priority-ordered task table.
package potl_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int ID_W = 4;
	localparam int PRIO_W = 8;
	localparam int TAG_W = 32;
	localparam int ACNT_W = 5;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_READ    = 2'd2,
		OP_FIND    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_MISS  = 2'd2,
		STAT_EMPTY = 2'd3
	} stat_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [ID_W-1:0]   slot_id;
		logic [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]  func_tag;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_slot;
		logic [TAG_W-1:0]  result_tag;
		stat_t             status;
		logic              last_of_run;
		logic [ACNT_W-1:0] active_count;
	} out_word_t;

	// one list position: which slot sits here and its key
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [SLOT_W-1:0] new_slot;
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] sid;
	} cmd_t;

	typedef struct packed {
		logic              find_hit;
		logic [SLOT_W-1:0] find_slot;
		logic [TAG_W-1:0]  del_tag;
		entry_t            rd_entry;
	} look_t;

endpackage

// File: src/potl_cell.sv
// One list position of the ordered chain: holds, takes a new entry, or shifts in from left or right.
module potl_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  potl_pkg::cmd_t   cmd,
	input  potl_pkg::entry_t left,
	input  potl_pkg::entry_t right,
	input  logic             pos_in,
	input  logic             hit_in,
	output potl_pkg::entry_t q,
	output logic             pos_out,
	output logic             hit_out
);

	potl_pkg::entry_t ent_q;
	potl_pkg::entry_t ent_d;
	logic             gt_here;
	logic             hit_here;

	// insert point: first empty position or first with strictly larger prio
	assign gt_here  = !ent_q.valid || (ent_q.prio > cmd.prio);
	assign hit_here = ent_q.valid && (ent_q.slot == cmd.sid);
	assign pos_out  = pos_in | gt_here;
	assign hit_out  = hit_in | hit_here;
	assign q        = ent_q;

	always_comb begin
		ent_d = ent_q;
		if (cmd.ins) begin
			if (pos_in) begin
				ent_d = left;
			end else if (gt_here) begin
				ent_d.valid = 1'b1;
				ent_d.slot  = cmd.new_slot;
				ent_d.prio  = cmd.prio;
				ent_d.tag   = cmd.tag;
			end
		end else if (cmd.rem) begin
			if (hit_out) begin
				ent_d = right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

// File: src/potl_chain.sv
// Row of list cells in priority order, with tag/slot lookups over the row.
module potl_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  potl_pkg::cmd_t              cmd,
	input  logic [potl_pkg::SLOT_W-1:0] rd_idx,
	output potl_pkg::look_t             look
);

	potl_pkg::entry_t                   ents [potl_pkg::SLOT_COUNT];
	potl_pkg::entry_t                   lefts [potl_pkg::SLOT_COUNT];
	potl_pkg::entry_t                   rights [potl_pkg::SLOT_COUNT];
	logic [potl_pkg::SLOT_COUNT:0]      pos_c;
	logic [potl_pkg::SLOT_COUNT:0]      hit_c;
	logic [potl_pkg::SLOT_COUNT-1:0]    match_vec;

	assign pos_c[0] = 1'b0;
	assign hit_c[0] = 1'b0;

	for (genvar i = 0; i < potl_pkg::SLOT_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lefts[i] = '0;
		end else begin : g_mid
			assign lefts[i] = ents[i-1];
		end
		if (i == potl_pkg::SLOT_COUNT - 1) begin : g_end
			assign rights[i] = '0;
		end else begin : g_inner
			assign rights[i] = ents[i+1];
		end

		potl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left    (lefts[i]),
			.right   (rights[i]),
			.pos_in  (pos_c[i]),
			.hit_in  (hit_c[i]),
			.q       (ents[i]),
			.pos_out (pos_c[i+1]),
			.hit_out (hit_c[i+1])
		);
	end

	always_comb begin
		match_vec    = '0;
		look.del_tag = '0;
		for (int i = 0; i < potl_pkg::SLOT_COUNT; i++) begin
			if (ents[i].valid && ents[i].tag == cmd.tag) begin
				match_vec[ents[i].slot] = 1'b1;
			end
			if (ents[i].valid && ents[i].slot == cmd.sid) begin
				look.del_tag = look.del_tag | ents[i].tag;
			end
		end
		// lowest slot number holding the tag
		look.find_hit  = |match_vec;
		look.find_slot = '0;
		for (int i = potl_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				look.find_slot = potl_pkg::SLOT_W'(i);
			end
		end
		look.rd_entry = ents[rd_idx];
	end

endmodule

// File: src/priority_ordered_task_table_core.sv
// Top level of the priority-ordered task table: control, slot map, output register.
//
//  channel | signals                       | dir | moves
//  --------+-------------------------------+-----+--------------------------------
//  in      | in_valid, in_ready, in_word   | in  | one operation word
//  out     | out_valid, out_ready, out_word| out | result words, last_of_run ends run
//
// Create, destroy and find answer with one result word; the cell row inserts or removes in place.
// Read order enters the read state on accept and streams one word per cycle from the row
// while the output register is free, and takes no new word until its last word is loaded.
// Reset empties the table at once. A stalled output word holds; input also waits
// while the output register is full and not being taken.
module priority_ordered_task_table_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  potl_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output potl_pkg::out_word_t out_word
);

	potl_pkg::state_t                state_q;
	potl_pkg::state_t                state_d;
	logic [potl_pkg::SLOT_COUNT-1:0] active_q;
	logic [potl_pkg::SLOT_COUNT-1:0] active_d;
	logic [potl_pkg::CNT_W-1:0]      cnt_q;
	logic [potl_pkg::CNT_W-1:0]      cnt_d;
	logic [potl_pkg::SLOT_W-1:0]     rd_idx_q;
	logic [potl_pkg::SLOT_W-1:0]     rd_idx_d;
	logic                            out_valid_q;
	potl_pkg::out_word_t             out_word_q;
	potl_pkg::out_word_t             out_next;
	logic                            out_load;
	logic                            out_free;
	logic                            acc;
	logic                            full;
	logic [potl_pkg::SLOT_W-1:0]     free_slot;
	logic                            sid_ok;
	logic                            del_hit;
	logic                            rd_last;
	potl_pkg::cmd_t                  cmd;
	potl_pkg::look_t                 look;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == potl_pkg::ST_IDLE) && out_free;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign full      = &active_q;
	assign sid_ok    = 32'(in_word.slot_id) < potl_pkg::SLOT_COUNT;
	assign del_hit   = sid_ok && active_q[potl_pkg::SLOT_W'(in_word.slot_id)];
	assign rd_last   = (potl_pkg::CNT_W'(rd_idx_q) + potl_pkg::CNT_W'(1)) == cnt_q;

	always_comb begin
		free_slot = '0;
		for (int i = potl_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_slot = potl_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		cmd.ins      = acc && in_word.operation == potl_pkg::OP_CREATE && !full;
		cmd.rem      = acc && in_word.operation == potl_pkg::OP_DESTROY && del_hit;
		cmd.new_slot = free_slot;
		cmd.prio     = in_word.priority_req;
		cmd.tag      = in_word.func_tag;
		cmd.sid      = potl_pkg::SLOT_W'(in_word.slot_id);
	end

	potl_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_idx (rd_idx_q),
		.look   (look)
	);

	always_comb begin
		state_d  = state_q;
		active_d = active_q;
		cnt_d    = cnt_q;
		rd_idx_d = rd_idx_q;
		out_load = 1'b0;
		out_next.result_slot  = '0;
		out_next.result_tag   = '0;
		out_next.status       = potl_pkg::STAT_OK;
		out_next.last_of_run  = 1'b1;
		out_next.active_count = potl_pkg::ACNT_W'(cnt_q);
		case (state_q)
			potl_pkg::ST_IDLE: begin
				if (acc) begin
					out_load = 1'b1;
					case (in_word.operation)
						potl_pkg::OP_CREATE: begin
							if (full) begin
								out_next.status = potl_pkg::STAT_FULL;
							end else begin
								active_d[free_slot]    = 1'b1;
								cnt_d                  = cnt_q + potl_pkg::CNT_W'(1);
								out_next.result_slot   = potl_pkg::ID_W'(free_slot);
								out_next.result_tag    = in_word.func_tag;
								out_next.active_count  = potl_pkg::ACNT_W'(cnt_d);
							end
						end
						potl_pkg::OP_DESTROY: begin
							out_next.result_slot = in_word.slot_id;
							if (del_hit) begin
								active_d[cmd.sid]     = 1'b0;
								cnt_d                 = cnt_q - potl_pkg::CNT_W'(1);
								out_next.result_tag   = look.del_tag;
								out_next.active_count = potl_pkg::ACNT_W'(cnt_d);
							end else begin
								out_next.status = potl_pkg::STAT_MISS;
							end
						end
						potl_pkg::OP_READ: begin
							if (cnt_q == '0) begin
								out_next.status = potl_pkg::STAT_EMPTY;
							end else begin
								// words come out of the row in the following cycles
								out_load = 1'b0;
								rd_idx_d = '0;
								state_d  = potl_pkg::ST_READ;
							end
						end
						potl_pkg::OP_FIND: begin
							if (look.find_hit) begin
								out_next.result_slot = potl_pkg::ID_W'(look.find_slot);
								out_next.result_tag  = in_word.func_tag;
							end else begin
								out_next.status = potl_pkg::STAT_MISS;
							end
						end
						default: begin
							out_next.status = potl_pkg::STAT_MISS;
						end
					endcase
				end
			end
			potl_pkg::ST_READ: begin
				if (out_free) begin
					out_load             = 1'b1;
					out_next.result_slot = potl_pkg::ID_W'(look.rd_entry.slot);
					out_next.result_tag  = look.rd_entry.tag;
					out_next.last_of_run = rd_last;
					rd_idx_d             = rd_idx_q + potl_pkg::SLOT_W'(1);
					if (rd_last) begin
						state_d = potl_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = potl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= potl_pkg::ST_IDLE;
			active_q    <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			cnt_q       <= cnt_d;
			rd_idx_q    <= rd_idx_d;
			out_valid_q <= out_load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= out_next;
		end
	end

endmodule
